>>> sv/cnft_pkg.sv
// Shared types and constants for the CNF text literal tokenizer.
// Used by every module of the block; depends on nothing else.
package cnft_pkg;

    // Character codes that the parser looks for.
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_C     = 8'h63;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Widths of the result fields.
    localparam int unsigned VAL_W  = 31;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned KIND_W = 3;

    localparam logic [VAL_W-1:0] ACC_MAX = {VAL_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_VAR_COUNT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLAUSE_COUNT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LITERAL      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLAUSE_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE         = 3'd4;

    // One registered input byte on its way to the parser.
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } byte_item_t;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
        logic              neg;
        logic [VAL_W-1:0]  clause;
        logic [POS_W-1:0]  pos;
        logic              done;
    } result_t;

endpackage

>>> sv/cnft_in_stage.sv
// Input register of the CNF tokenizer: holds one accepted byte until the
// parser consumes it. Depends on cnft_pkg.
module cnft_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                step,
    output cnft_pkg::byte_item_t item
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] data_reg;

    // The register is free when empty or when its byte is consumed now.
    assign in_ready = !vld_reg || step;
    assign vld_next = in_ready ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
        end
    end

    assign item.vld  = vld_reg;
    assign item.data = data_reg;

endmodule

>>> sv/cnft_parse_core.sv
// Parser state and the single-byte step logic of the CNF tokenizer.
// Depends on cnft_pkg.
module cnft_parse_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cnft_pkg::byte_item_t item,
    input  logic                 step,
    output logic                 res_vld,
    output cnft_pkg::result_t    res
);

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_COMMENT,
        PH_VARS,
        PH_CLAUSES,
        PH_LITERALS,
        PH_DONE
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic                           in_num_reg, in_num_next;
    logic [cnft_pkg::VAL_W-1:0]     acc_reg, acc_next;
    logic                           minus_reg, minus_next;
    logic [cnft_pkg::VAL_W-1:0]     clause_reg, clause_next;
    logic [cnft_pkg::POS_W-1:0]     pos_reg, pos_next;

    logic [7:0]                     b;
    logic                           is_end;
    logic                           is_digit;
    logic [3:0]                     dig;
    logic [cnft_pkg::VAL_W+3:0]     acc_ext;
    logic [cnft_pkg::VAL_W+3:0]     prod;
    logic [cnft_pkg::VAL_W-1:0]     acc_sat;
    logic                           fin;
    logic                           fin_last;

    assign b        = item.data;
    assign is_end   = (b == 8'h00) || b[7];
    assign is_digit = (b >= cnft_pkg::CHAR_ZERO) && (b <= cnft_pkg::CHAR_NINE);
    assign dig      = b[3:0];

    // Accumulator times ten plus the new digit, held at the maximum.
    assign acc_ext = {4'b0000, acc_reg};
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{cnft_pkg::VAL_W{1'b0}}, dig};
    assign acc_sat = (prod > {4'b0000, cnft_pkg::ACC_MAX}) ? cnft_pkg::ACC_MAX
                                                           : prod[cnft_pkg::VAL_W-1:0];

    // Step logic for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        in_num_next = in_num_reg;
        acc_next    = acc_reg;
        minus_next  = minus_reg;
        clause_next = clause_reg;
        pos_next    = pos_reg;
        res_vld     = 1'b0;
        res         = '0;
        fin         = 1'b0;
        fin_last    = 1'b0;

        unique case (phase_reg)
            PH_LINE_START:
            begin
                if (is_end)
                begin
                    res_vld  = 1'b1;
                    res.kind = cnft_pkg::KIND_NONE;
                    res.done = 1'b1;
                end
                else
                begin
                    phase_next = (b == cnft_pkg::CHAR_C) ? PH_COMMENT : PH_VARS;
                end
            end
            PH_COMMENT:
            begin
                if (is_end)
                begin
                    res_vld  = 1'b1;
                    res.kind = cnft_pkg::KIND_NONE;
                    res.done = 1'b1;
                end
                else if (b == cnft_pkg::CHAR_LF)
                begin
                    phase_next = PH_LINE_START;
                end
            end
            PH_VARS, PH_CLAUSES, PH_LITERALS:
            begin
                if (is_end)
                begin
                    if (in_num_reg)
                    begin
                        fin      = 1'b1;
                        fin_last = 1'b1;
                    end
                    else
                    begin
                        res_vld  = 1'b1;
                        res.kind = cnft_pkg::KIND_NONE;
                        res.done = 1'b1;
                    end
                end
                else if (!in_num_reg)
                begin
                    if (is_digit)
                    begin
                        in_num_next = 1'b1;
                        acc_next    = {{(cnft_pkg::VAL_W-4){1'b0}}, dig};
                        minus_next  = 1'b0;
                    end
                    else if (b == cnft_pkg::CHAR_MINUS)
                    begin
                        in_num_next = 1'b1;
                        acc_next    = '0;
                        minus_next  = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // A finished number turns into a token according to the phase.
        if (fin)
        begin
            in_num_next = 1'b0;
            acc_next    = '0;
            minus_next  = 1'b0;
            res_vld     = 1'b1;
            res.neg     = minus_reg;
            priority if (phase_reg == PH_VARS)
            begin
                phase_next = PH_CLAUSES;
                res.kind   = cnft_pkg::KIND_VAR_COUNT;
                res.value  = acc_reg;
                res.done   = fin_last;
            end
            else if (phase_reg == PH_CLAUSES)
            begin
                res.kind  = cnft_pkg::KIND_CLAUSE_COUNT;
                res.value = acc_reg;
                if (minus_reg || (acc_reg == '0))
                begin
                    res.done = 1'b1;
                end
                else
                begin
                    clause_next = acc_reg - 1'b1;
                    pos_next    = '0;
                    phase_next  = PH_LITERALS;
                    res.done    = fin_last;
                end
            end
            else
            begin
                res.clause = clause_reg;
                res.pos    = pos_reg;
                if (acc_reg == '0)
                begin
                    res.kind = cnft_pkg::KIND_CLAUSE_END;
                    res.neg  = 1'b0;
                    if ((clause_reg == '0) || fin_last)
                    begin
                        res.done = 1'b1;
                    end
                    else
                    begin
                        clause_next = clause_reg - 1'b1;
                        pos_next    = '0;
                    end
                end
                else
                begin
                    res.kind  = cnft_pkg::KIND_LITERAL;
                    res.value = acc_reg - 1'b1;
                    res.done  = fin_last;
                    if (pos_reg != cnft_pkg::POS_MAX)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
        end

        // Any result that ends the stream parks the parser.
        if (res_vld && res.done)
        begin
            phase_next = PH_DONE;
        end
    end

    // Parser state, advanced once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LINE_START;
            in_num_reg <= 1'b0;
            acc_reg    <= '0;
            minus_reg  <= 1'b0;
            clause_reg <= '0;
            pos_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            in_num_reg <= in_num_next;
            acc_reg    <= acc_next;
            minus_reg  <= minus_next;
            clause_reg <= clause_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

>>> sv/cnft_out_stage.sv
// Result register of the CNF tokenizer: holds one result transaction until
// the receiver takes it. Depends on cnft_pkg.
module cnft_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cnft_pkg::result_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output cnft_pkg::result_t out_res
);

    logic              vld_reg;
    logic              vld_next;
    cnft_pkg::result_t res_reg;

    // The register can take a new result when empty or being drained now.
    assign free     = !vld_reg || out_ready;
    assign vld_next = load ? 1'b1 : (vld_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

>>> sv/cnf_text_literal_tokenizer.sv
// CNF text literal tokenizer: top level.
// Takes one text byte per input transaction on in_valid/in_ready/data_byte.
// Skips leading comment lines, drops the first byte of the header line,
// then reads the variable count, the clause count and the literals.
// Each byte gives at most one result transaction on out_valid/out_ready with
// token_kind, number_value, is_negated, clause_number, literal_position and
// stream_done. Bytes that complete no token and do not end the stream give no result.
// A byte passes an input register, then the combinational parser step
// logic, then the result register, which takes its result, if any, when the
// byte is consumed. One byte per cycle is consumed while the result register
// has room; the parser step is one multiply-by-ten add and saturation
// compare on the accumulator.
// When the receiver stalls, the result register holds its transaction, the
// byte in the input register waits, and in_ready falls once both are full.
// Reset clears both registers and returns the parser to the start of a line.
// Once parsing has ended, further bytes are accepted and give no result.
// Depends on cnft_pkg, cnft_in_stage, cnft_parse_core and cnft_out_stage.
module cnf_text_literal_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  token_kind,
    output logic [30:0] number_value,
    output logic        is_negated,
    output logic [30:0] clause_number,
    output logic [15:0] literal_position,
    output logic        stream_done
);

    cnft_pkg::byte_item_t item;
    cnft_pkg::result_t    res;
    cnft_pkg::result_t    out_res;
    logic                 res_vld;
    logic                 free;
    logic                 step;

    // A byte is consumed when present and the result register has room.
    assign step = item.vld && free;

    cnft_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .step      (step),
        .item      (item)
    );

    cnft_parse_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .step    (step),
        .res_vld (res_vld),
        .res     (res)
    );

    cnft_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_vld),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign token_kind       = out_res.kind;
    assign number_value     = out_res.value;
    assign is_negated       = out_res.neg;
    assign clause_number    = out_res.clause;
    assign literal_position = out_res.pos;
    assign stream_done      = out_res.done;

endmodule
